// File: sv/acbc_pkg.sv
// shared types, constants and aes helper functions for the cbc decryptor
package acbc_pkg;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic [4:0]  byte_count;
    logic        final_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic [4:0]  keep_bytes;
    logic        message_end;
    logic [1:0]  status;
  } out_item_t;

  localparam int BLOCK_BYTES = 16;
  localparam int KEY_BYTES   = 32;
  localparam int RK_DEPTH    = 30;
  localparam int NUM_ROUNDS  = 14;

  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_IVH  = 3'd4;
  localparam logic [2:0] REG_IVL  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_PAD_HIGH = 2'd1;
  localparam logic [1:0] ST_PAD_ZERO = 2'd2;
  localparam logic [1:0] ST_PAD_BAD  = 2'd3;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 4; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    fmul = p;
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    logic [7:0] sq;
    b = 8'h01;
    sq = x;
    // x^254 = x^2 * x^4 * ... * x^128
    for (int i = 0; i < 7; i++) begin
      sq = fmul(sq, sq);
      b = fmul(b, sq);
    end
    sbox_calc = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^
                {b[3:0], b[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [7:0] inv_sbox_calc(input logic [7:0] s);
    logic [7:0] y;
    logic [7:0] b;
    // inverse affine step, then x^254
    y = s ^ 8'h63;
    y = {y[6:0], y[7]} ^ {y[4:0], y[7:5]} ^ {y[1:0], y[7:2]};
    b = 8'h01;
    for (int i = 0; i < 7; i++) begin
      y = fmul(y, y);
      b = fmul(b, y);
    end
    inv_sbox_calc = b;
  endfunction

  function automatic logic [2047:0] build_fwd_tbl();
    logic [2047:0] t;
    t = '0;
    for (int x = 0; x < 256; x++) t[8 * x +: 8] = sbox_calc(8'(x));
    build_fwd_tbl = t;
  endfunction

  function automatic logic [2047:0] build_inv_tbl();
    logic [2047:0] t;
    t = '0;
    for (int x = 0; x < 256; x++) t[8 * x +: 8] = inv_sbox_calc(8'(x));
    build_inv_tbl = t;
  endfunction

  // substitution tables, filled at elaboration
  localparam logic [2047:0] SBOX_TBL     = build_fwd_tbl();
  localparam logic [2047:0] INV_SBOX_TBL = build_inv_tbl();

  function automatic logic [7:0] sbox(input logic [7:0] x);
    sbox = SBOX_TBL[{x, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] s);
    inv_sbox = INV_SBOX_TBL[{s, 3'b000} +: 8];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // state byte j lives at bits [127-8j -: 8]
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = inv_sbox(s[127 - 8 * (r + 4 * ((c - r) & 3)) -: 8]);
      end
    end
    inv_shift_sub = t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32 * c -: 8];
      a1 = s[119 - 32 * c -: 8];
      a2 = s[111 - 32 * c -: 8];
      a3 = s[103 - 32 * c -: 8];
      t[127 - 32 * c -: 8] = gmul(a0, 4'd14) ^ gmul(a1, 4'd11) ^ gmul(a2, 4'd13) ^ gmul(a3, 4'd9);
      t[119 - 32 * c -: 8] = gmul(a0, 4'd9) ^ gmul(a1, 4'd14) ^ gmul(a2, 4'd11) ^ gmul(a3, 4'd13);
      t[111 - 32 * c -: 8] = gmul(a0, 4'd13) ^ gmul(a1, 4'd9) ^ gmul(a2, 4'd14) ^ gmul(a3, 4'd11);
      t[103 - 32 * c -: 8] = gmul(a0, 4'd11) ^ gmul(a1, 4'd13) ^ gmul(a2, 4'd9) ^ gmul(a3, 4'd14);
    end
    inv_mix = t;
  endfunction

endpackage

// File: sv/aes256_cbc_decrypt_unpad.sv
// aes-256 cbc decryptor with pkcs7 padding check, top level
// One 128-bit ciphertext block per request. The round keys sit in a 30 x 64
// memory with a registered read, so each 128-bit round key takes two reads and
// the fifteen key additions run on one round unit. A block passes a key read
// step, the round steps and an unpad step from acceptance to result, and no
// new request is taken until the last block has left its unpad step. After
// any key write the next request first expands the schedule, one 32-bit word
// a cycle. The result sits in an output register; the next block may be taken
// while it waits and holds in its unpad step until the register is free.
module aes256_cbc_decrypt_unpad (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  acbc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output acbc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata
);
  import acbc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KEXP = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]   state_r, state_nxt;
  logic [63:0]  key_r [4];
  logic [127:0] iv_r;
  logic [127:0] prev_r;
  logic         sched_ok_r;
  logic         msg_start_r;

  logic [63:0]  rk_mem [RK_DEPTH];
  logic [63:0]  rk_rd_r;
  logic [4:0]   rk_addr;
  logic         rk_we;
  logic [63:0]  rk_wdata;

  logic [31:0]  w_r [8];     // sliding key expansion window
  logic [5:0]   wi_r;        // word index being produced
  logic [4:0]   kcnt_r;      // memory entry being written
  logic [7:0]   rc_r;
  logic [31:0]  whi_r;

  logic [127:0] blk_r;
  logic [127:0] st_r;
  logic         fin_r;
  logic [3:0]   rnd_r;       // round whose key is in flight
  logic         half_r;
  logic [63:0]  khi_r;
  out_item_t    out_r;
  logic         out_v_r;
  logic         fin_go;

  // ---- key expansion, one new word per cycle, two words per entry
  logic [31:0] wnew;
  logic [31:0] tw;
  always_comb begin
    tw = w_r[7];
    if (wi_r[2:0] == 3'd0) tw = sub_word({w_r[7][23:0], w_r[7][31:24]}) ^ {rc_r, 24'h0};
    else if (wi_r[2:0] == 3'd4) tw = sub_word(w_r[7]);
    wnew = w_r[0] ^ tw;
  end

  // ---- masked input block
  logic [127:0] in_raw;
  logic [127:0] in_blk;
  assign in_raw = {in_data.cipher_high, in_data.cipher_low};
  always_comb begin
    for (int j = 0; j < BLOCK_BYTES; j++) begin
      in_blk[127 - 8 * j -: 8] = (5'(j) < in_data.byte_count) ? in_raw[127 - 8 * j -: 8] :
                                 8'h00;
    end
  end

  // ---- round unit
  logic [127:0] rk_full;
  logic [127:0] st_add;
  logic [127:0] st_round;
  assign rk_full  = {khi_r, rk_rd_r};
  always_comb begin
    st_add = st_r ^ rk_full;
    if (rnd_r == 4'(NUM_ROUNDS)) st_add = blk_r ^ rk_full;
    st_round = (rnd_r == 4'd0) ? st_add :
               (rnd_r == 4'(NUM_ROUNDS)) ? inv_shift_sub(st_add) :
               inv_shift_sub(inv_mix(st_add));
  end

  // ---- unpad on the finished state
  logic [127:0] pt;
  logic [7:0]   pad;
  logic [1:0]   stat;
  always_comb begin
    pt = st_r ^ (msg_start_r ? iv_r : prev_r);
    pad = pt[7:0];
    stat = ST_OK;
    if (pad > 8'd16) stat = ST_PAD_HIGH;
    else if (pad == 8'd0) stat = ST_PAD_ZERO;
    else begin
      for (int j = 1; j < BLOCK_BYTES; j++) begin
        if (8'(j) < pad && pt[8 * j +: 8] != pad) stat = ST_PAD_BAD;
      end
    end
  end

  // the finished block waits here while the previous result is still held
  assign fin_go    = (state_r == S_FIN) && (!out_v_r || out_ready);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  always_comb begin
    rk_we = 1'b0;
    rk_wdata = {whi_r, wnew};
    rk_addr = {rnd_r, half_r};
    // applying a round prefetches the high word of the next one
    if (state_r == S_RND && !half_r && rnd_r != 4'd0) rk_addr = {rnd_r - 4'd1, 1'b0};
    if (state_r == S_KEXP) begin
      rk_addr = kcnt_r;
      rk_we = wi_r[0];
      if (wi_r < 6'd8) rk_wdata = {key_r[wi_r[2:1]]};
    end
  end

  always_ff @(posedge clk) begin
    if (rk_we) rk_mem[rk_addr] <= rk_wdata;
    rk_rd_r <= rk_mem[rk_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid && in_ready) state_nxt = sched_ok_r ? S_RD : S_KEXP;
      S_KEXP: if (wi_r == 6'd59) state_nxt = S_RD;
      S_RD:   state_nxt = S_RND;
      S_RND:  if (!half_r && rnd_r == 4'd0) state_nxt = S_FIN;
      S_FIN:  if (fin_go) state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sched_ok_r <= 1'b0;
      msg_start_r <= 1'b1;
      out_v_r <= 1'b0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      iv_r <= '0;
      prev_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
            key_r[cfg_index[1:0]] <= cfg_wdata;
            sched_ok_r <= 1'b0;
          end
          REG_IVH: iv_r[127:64] <= cfg_wdata;
          REG_IVL: iv_r[63:0] <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_v_r && out_ready) out_v_r <= 1'b0;
      if (state_r == S_KEXP && wi_r == 6'd59) sched_ok_r <= 1'b1;
      if (fin_go) begin
        out_v_r <= 1'b1;
        prev_r <= blk_r;
        msg_start_r <= fin_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        blk_r <= in_blk;
        fin_r <= in_data.final_block;
        wi_r <= '0;
        kcnt_r <= '0;
        rc_r <= 8'h01;
        rnd_r <= 4'(NUM_ROUNDS);
        half_r <= 1'b0;
      end
      S_KEXP: begin
        // first eight words come straight from the key
        if (wi_r < 6'd8) begin
          w_r[wi_r[2:0]] <= wi_r[0] ? key_r[wi_r[2:1]][31:0] : key_r[wi_r[2:1]][63:32];
          whi_r <= key_r[wi_r[2:1]][63:32];
        end else begin
          for (int i = 0; i < 7; i++) w_r[i] <= w_r[i + 1];
          w_r[7] <= wnew;
          whi_r <= wnew;
          if (wi_r[2:0] == 3'd0) rc_r <= xt(rc_r);
        end
        if (wi_r[0]) kcnt_r <= kcnt_r + 5'd1;
        wi_r <= wi_r + 6'd1;
        if (wi_r == 6'd59) begin
          rnd_r <= 4'(NUM_ROUNDS);
          half_r <= 1'b0;
        end
      end
      S_RD: half_r <= 1'b1;
      S_RND: begin
        // odd phase latches the high word, even phase applies the round
        if (half_r) begin
          khi_r <= rk_rd_r;
          half_r <= 1'b0;
        end else begin
          st_r <= st_round;
          if (rnd_r != 4'd0) rnd_r <= rnd_r - 4'd1;
          half_r <= 1'b1;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_r.plain_high <= pt[127:64];
          out_r.plain_low <= pt[63:0];
          out_r.message_end <= fin_r;
          out_r.status <= fin_r ? stat : ST_OK;
          out_r.keep_bytes <= !fin_r ? 5'd16 : (stat != ST_OK) ? 5'd0 : 5'(8'd16 - pad);
        end
      end
      default: ;
    endcase
  end

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_ready) |=> (out_v_r && $stable(out_r)))
    else $error("result changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

  a_fin_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> out_v_r)
    else $error("finished block produced no result");

  a_sched_before_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RND) |-> (sched_ok_r || cfg_we || $past(cfg_we)))
    else $error("rounds run without a key schedule");

endmodule

// File: sim/tb_aes256_cbc_decrypt_unpad.sv
// self-checking testbench for the aes-256 cbc decryptor with pkcs7 unpad
module tb_aes256_cbc_decrypt_unpad;
  timeunit 1ns;
  timeprecision 1ps;
  import acbc_pkg::*;

  localparam int DRAIN_CYCLES = 64;

  typedef enum logic [1:0] {ROW_RAW, ROW_PAD, ROW_MISMATCH} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  cnt;
    logic        fin;
    logic [7:0]  pad;
    logic        has_meta;
    logic [4:0]  keep;
    logic        mend;
    logic [1:0]  stat;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  aes256_cbc_decrypt_unpad u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [7:0]   fbox [256];
  logic [7:0]   ibox [256];
  logic [63:0]  key_reg [4];
  logic [63:0]  iv_hi, iv_lo;
  logic [127:0] rkey [15];
  logic [127:0] prev_block;
  logic         new_message;

  out_item_t plain_q[$];
  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_good = 0;
  int n_bad = 0;
  int n_settings = 0;
  int rx_gap = 0;
  bit rx_busy_free = 0;

  function automatic logic [7:0] gf_mul8(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic void build_boxes();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = (x == 0) ? 8'h00 : 8'h01;
      if (x != 0)
        for (int i = 0; i < 254; i++) inv = gf_mul8(inv, x[7:0]);
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]} ^
          {inv[3:0], inv[7:4]} ^ 8'h63;
      fbox[x] = s;
      ibox[s] = x[7:0];
    end
  endfunction

  function automatic logic [31:0] word_sub(input logic [31:0] w);
    return {fbox[w[31:24]], fbox[w[23:16]], fbox[w[15:8]], fbox[w[7:0]]};
  endfunction

  function automatic void expand_schedule();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) begin
      w[2*i]   = key_reg[i][63:32];
      w[2*i+1] = key_reg[i][31:0];
    end
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if ((i & 7) == 0) begin
        t = word_sub({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_mul8(rc, 8'h02);
      end else if ((i & 7) == 4) begin
        t = word_sub(t);
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r < 15; r++) rkey[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endfunction

  // byte j of a block sits at bits [127-8j -: 8]
  function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
    logic [127:0] t;
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        t[127 - 8*(r + 4*c) -: 8] = ibox[s[127 - 8*(r + 4*((c - r) & 3)) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] unmix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      t[127 - 32*c -: 8] = gf_mul8(a0, 8'd14) ^ gf_mul8(a1, 8'd11) ^ gf_mul8(a2, 8'd13) ^
                           gf_mul8(a3, 8'd9);
      t[119 - 32*c -: 8] = gf_mul8(a0, 8'd9) ^ gf_mul8(a1, 8'd14) ^ gf_mul8(a2, 8'd11) ^
                           gf_mul8(a3, 8'd13);
      t[111 - 32*c -: 8] = gf_mul8(a0, 8'd13) ^ gf_mul8(a1, 8'd9) ^ gf_mul8(a2, 8'd14) ^
                           gf_mul8(a3, 8'd11);
      t[103 - 32*c -: 8] = gf_mul8(a0, 8'd11) ^ gf_mul8(a1, 8'd13) ^ gf_mul8(a2, 8'd9) ^
                           gf_mul8(a3, 8'd14);
    end
    return t;
  endfunction

  function automatic logic [127:0] aes_decrypt(input logic [127:0] c);
    logic [127:0] s;
    s = c ^ rkey[14];
    for (int r = 13; r >= 1; r--) s = unmix(unshift_unsub(s) ^ rkey[r]);
    return unshift_unsub(s) ^ rkey[0];
  endfunction

  function automatic void model_write(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      REG_KEY0: key_reg[0] = val;
      REG_KEY1: key_reg[1] = val;
      REG_KEY2: key_reg[2] = val;
      REG_KEY3: key_reg[3] = val;
      REG_IVH:  iv_hi = val;
      REG_IVL:  iv_lo = val;
      default: ;
    endcase
    if (idx <= REG_KEY3) expand_schedule();
  endfunction

  function automatic out_item_t decrypt_block(input in_item_t it);
    out_item_t   r;
    logic [127:0] blk, pt;
    int          cnt;
    logic [7:0]  pad;
    cnt = (it.byte_count > 16) ? 16 : it.byte_count;
    blk = {it.cipher_high, it.cipher_low};
    for (int j = cnt; j < 16; j++) blk[127 - 8*j -: 8] = 8'h00;
    pt = aes_decrypt(blk) ^ (new_message ? {iv_hi, iv_lo} : prev_block);
    prev_block = blk;
    new_message = it.final_block;
    r.plain_high = pt[127:64];
    r.plain_low = pt[63:0];
    r.keep_bytes = 5'd16;
    r.message_end = it.final_block;
    r.status = ST_OK;
    if (it.final_block) begin
      pad = pt[7:0];
      if (pad > 16) r.status = ST_PAD_HIGH;
      else if (pad == 0) r.status = ST_PAD_ZERO;
      else
        for (int j = 1; j < pad; j++)
          if (pt[8*j +: 8] != pad) r.status = ST_PAD_BAD;
      r.keep_bytes = (r.status == ST_OK) ? 5'(16 - pad) : 5'd0;
    end
    return r;
  endfunction

  // sender: random gap (none while rx_busy_free), then hold the request until accepted
  task automatic send_block(input in_item_t it, input bit has_meta,
                            input logic [4:0] keep, input logic mend, input logic [1:0] stat);
    int gap;
    out_item_t e;
    gap = rx_busy_free ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = decrypt_block(it);
    if (has_meta) begin
      e.keep_bytes = keep;
      e.message_end = mend;
      e.status = stat;
    end
    plain_q.push_back(e);
    n_in++;
  endtask

  task automatic send_plain(input logic [63:0] hi, input logic [63:0] lo,
                            input logic [4:0] cnt, input logic fin);
    in_item_t it;
    it.cipher_high = hi;
    it.cipher_low = lo;
    it.byte_count = cnt;
    it.final_block = fin;
    send_block(it, 1'b0, '0, 1'b0, ST_OK);
  endtask

  // two full blocks whose last decrypts to a chosen pad tail, optionally with one byte spoiled
  task automatic send_padded_pair(input logic [7:0] pad, input bit mismatch,
                                  input bit has_meta, input logic [4:0] keep,
                                  input logic [1:0] stat);
    logic [127:0] want, c_last, c_prev;
    in_item_t it;
    want = {$urandom, $urandom, $urandom, $urandom};
    if (pad >= 1 && pad <= 16)
      for (int j = 0; j < pad; j++) want[8*j +: 8] = pad;
    else
      want[7:0] = pad;
    if (mismatch) want[8 +: 8] = pad ^ 8'(1 + $urandom_range(0, 254));
    c_last = {$urandom, $urandom, $urandom, $urandom};
    c_prev = aes_decrypt(c_last) ^ want;
    send_plain(c_prev[127:64], c_prev[63:0], 5'd16, 1'b0);
    it.cipher_high = c_last[127:64];
    it.cipher_low = c_last[63:0];
    it.byte_count = 5'd16;
    it.final_block = 1'b1;
    send_block(it, has_meta, keep, 1'b1, stat);
  endtask

  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (plain_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    model_write(idx, val);
  endtask

  task automatic new_setting(input int style);
    logic [63:0] v;
    for (int i = 0; i < 8; i++) begin
      case (style)
        0: v = '0;
        1: v = '1;
        default: v = {$urandom, $urandom};
      endcase
      // some phases touch only part of the registers
      if (style < 2 || i >= 6 || $urandom_range(0, 3) != 0) cfg_write(i[2:0], v);
    end
    @(negedge clk) cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic random_messages(input int count);
    int len;
    int pick;
    while (count > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        len = $urandom_range(2, 6);
        for (int b = 0; b < len - 2; b++)
          send_plain({$urandom, $urandom}, {$urandom, $urandom}, 5'd16, 1'b0);
        if (pick < 60)
          send_padded_pair(8'($urandom_range(1, 16)), 1'b0, 1'b0, '0, ST_OK);
        else
          send_padded_pair(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0,
                           ST_OK);
        count -= len;
      end else begin
        len = $urandom_range(1, 4);
        for (int b = 0; b < len; b++)
          send_plain({$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom_range(0, 31)),
                     (b == len - 1) ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 9) == 0));
        count -= len;
      end
    end
  endtask

  // result side
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (plain_q.size() == 0) begin
        $error("result with nothing expected: %p", out_data);
        errors++;
      end else begin
        e = plain_q.pop_front();
        if (out_data.plain_high !== e.plain_high) begin
          $error("plain_high expected %h actual %h", e.plain_high, out_data.plain_high);
          errors++;
        end
        if (out_data.plain_low !== e.plain_low) begin
          $error("plain_low expected %h actual %h", e.plain_low, out_data.plain_low);
          errors++;
        end
        if (out_data.keep_bytes !== e.keep_bytes) begin
          $error("keep_bytes expected %0d actual %0d", e.keep_bytes, out_data.keep_bytes);
          errors++;
        end
        if (out_data.message_end !== e.message_end) begin
          $error("message_end expected %0d actual %0d", e.message_end, out_data.message_end);
          errors++;
        end
        if (out_data.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_data.status);
          errors++;
        end
        if (e.message_end) begin
          if (e.status == ST_OK) n_good++;
          else n_bad++;
        end
      end
      n_out++;
      if (n_out == 200) rx_gap = 300;
      else if (rx_busy_free) rx_gap = 0;
      else rx_gap = $urandom_range(0, 9);
    end
  end

  always @(negedge clk) begin
    if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("aes256_cbc_decrypt_unpad regression: fail");
    $finish;
  end

  initial begin
    dir_row_t rows [$];
    int phase;
    build_boxes();
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    iv_hi = '0;
    iv_lo = '0;
    prev_block = '0;
    new_message = 1'b1;
    expand_schedule();

    rows = '{
      '{ROW_RAW, '0, '0, 5'd16, 1'b0, 8'd0, 1'b1, 5'd16, 1'b0, ST_OK},
      '{ROW_RAW, '1, '1, 5'd16, 1'b0, 8'd0, 1'b1, 5'd16, 1'b0, ST_OK},
      '{ROW_RAW, '1, '1, 5'd0, 1'b0, 8'd0, 1'b1, 5'd16, 1'b0, ST_OK},
      '{ROW_RAW, '1, '1, 5'd31, 1'b0, 8'd0, 1'b1, 5'd16, 1'b0, ST_OK},
      '{ROW_RAW, '1, '1, 5'd17, 1'b0, 8'd0, 1'b1, 5'd16, 1'b0, ST_OK},
      '{ROW_RAW, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd1, 1'b0, 8'd0, 1'b1,
        5'd16, 1'b0, ST_OK},
      '{ROW_RAW, '1, '1, 5'd15, 1'b0, 8'd0, 1'b1, 5'd16, 1'b0, ST_OK},
      '{ROW_RAW, '1, '1, 5'd5, 1'b1, 8'd0, 1'b0, '0, 1'b0, ST_OK},
      '{ROW_RAW, '0, '0, 5'd16, 1'b1, 8'd0, 1'b0, '0, 1'b0, ST_OK},
      '{ROW_RAW, '1, '1, 5'd0, 1'b1, 8'd0, 1'b0, '0, 1'b0, ST_OK},
      '{ROW_PAD, '0, '0, 5'd16, 1'b1, 8'd1, 1'b1, 5'd15, 1'b1, ST_OK},
      '{ROW_PAD, '0, '0, 5'd16, 1'b1, 8'd16, 1'b1, 5'd0, 1'b1, ST_OK},
      '{ROW_PAD, '0, '0, 5'd16, 1'b1, 8'd8, 1'b1, 5'd8, 1'b1, ST_OK},
      '{ROW_PAD, '0, '0, 5'd16, 1'b1, 8'd0, 1'b1, 5'd0, 1'b1, ST_PAD_ZERO},
      '{ROW_PAD, '0, '0, 5'd16, 1'b1, 8'd17, 1'b1, 5'd0, 1'b1, ST_PAD_HIGH},
      '{ROW_PAD, '0, '0, 5'd16, 1'b1, 8'd255, 1'b1, 5'd0, 1'b1, ST_PAD_HIGH},
      '{ROW_MISMATCH, '0, '0, 5'd16, 1'b1, 8'd2, 1'b1, 5'd0, 1'b1, ST_PAD_BAD},
      '{ROW_MISMATCH, '0, '0, 5'd16, 1'b1, 8'd16, 1'b1, 5'd0, 1'b1, ST_PAD_BAD}
    };

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // reset settings first, then all ones
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        wait_idle();
        new_setting(1);
      end
      foreach (rows[i]) begin
        if (rows[i].kind == ROW_RAW)
          send_block('{rows[i].hi, rows[i].lo, rows[i].cnt, rows[i].fin},
                     rows[i].has_meta, rows[i].keep, rows[i].mend, rows[i].stat);
        else
          send_padded_pair(rows[i].pad, rows[i].kind == ROW_MISMATCH, 1'b1,
                           rows[i].keep, rows[i].stat);
      end
    end

    for (phase = 0; phase < 6; phase++) begin
      wait_idle();
      new_setting(phase == 5 ? 0 : 2);
      rx_busy_free = (phase == 2);
      random_messages(260);
    end
    rx_busy_free = 0;

    wait_idle();
    $display("sent %0d blocks, %0d results, %0d key/iv settings", n_in, n_out, n_settings);
    $display("messages ending with good pad: %0d, with bad pad: %0d", n_good, n_bad);
    if (plain_q.size() != 0) begin
      $error("%0d results never arrived", plain_q.size());
      errors++;
    end
    if (errors == 0)
      $display("aes256_cbc_decrypt_unpad regression: pass");
    else
      $display("aes256_cbc_decrypt_unpad regression: fail");
    $finish;
  end

endmodule
